// ===== rtl/core/rpc_pkg.sv =====
// Package for the retransmission packet cache: types, codes, reset values.
// No dependencies.
`default_nettype none
package rpc_pkg;
   localparam int SlotCountDefault = 256;
   localparam logic [31:0] RetentionReset = 32'd1000;
   localparam logic [8:0]  MaxPacketsReset = 9'd256;
   localparam logic [31:0] MaxBytesReset = 32'd1048576;

   typedef enum logic [1:0] {
      ACT_STORE = 2'd0, ACT_FIND = 2'd1, ACT_STATS = 2'd2, ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_STORE = 3'd0, KIND_HIT = 3'd1, KIND_MISS = 3'd2,
      KIND_COUNTER = 3'd3, KIND_CLEARED = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RETENTION = 2'd0, CSR_MAX_PACKETS = 2'd1, CSR_MAX_BYTES = 2'd2
   } csr_index_type;

   localparam logic [3:0] CNT_STORED   = 4'd0;
   localparam logic [3:0] CNT_REPLACED = 4'd1;
   localparam logic [3:0] CNT_CAPACITY = 4'd2;
   localparam logic [3:0] CNT_EXPIRED  = 4'd3;
   localparam logic [3:0] CNT_LOOKUPS  = 4'd4;
   localparam logic [3:0] CNT_HITS     = 4'd5;
   localparam logic [3:0] CNT_MISSES   = 4'd6;
   localparam logic [3:0] CNT_PACKETS  = 4'd7;
   localparam logic [3:0] CNT_BYTES    = 4'd8;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PRUNE_RD, ST_PRUNE_CHK, ST_DROP_RD, ST_DROP_WR,
      ST_SCAN, ST_SCAN_CHK, ST_FIND_RD, ST_FIND_OUT, ST_STORE_CHK,
      ST_FREE, ST_FREE_CHK, ST_APPEND, ST_LIMIT, ST_STATS, ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/retransmission_packet_cache_core.sv =====
// Retransmission packet cache top level: slot memories, linked list and
// the sequencer. Depends on rpc_pkg.
`default_nettype none
//  channel | dir | tdata fields (low bit up)                          | tuser
//  req_    | in  | action, seq_no, packet_length,                      | -
//          |     | buffer_handle, now_time                             |
//  rsp_    | out | stored, found_handle, found_length, counter_index,   | kind
//          |     | counter_value                                       |  tlast=last
//  csr_    | in  | write enable, index, 32-bit data                     | -
// One word in work at a time. Expiry reads the oldest entry and drops it while it
// has expired. Lookup walks the slots one by one, comparing sequence numbers; a
// store adds a free-slot search and limit evictions. Reset is synchronous and
// clears valid bits in flops; slot contents are undefined until written.
// req_tready is low while an item is in work; results wait in rsp_ registers.
module retransmission_packet_cache_core #(
   parameter int SLOT_COUNT = rpc_pkg::SlotCountDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[1:0], seq_no[17:2], packet_length[33:18],
   // buffer_handle[65:34], now_time[113:66], zero fill
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // stored[0], found_handle[32:1], found_length[48:33], counter_index[52:49],
   // counter_value[116:53], zero fill
   output logic [119:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser, // kind
   output logic              rsp_tlast,
   input  wire logic         csr_wen,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   // slot memories
   logic [15:0] mem_seq  [SLOT_COUNT];
   logic [15:0] mem_len  [SLOT_COUNT];
   logic [47:0] mem_time [SLOT_COUNT];
   logic [31:0] mem_hdl  [SLOT_COUNT];
   logic [AW-1:0] mem_next [SLOT_COUNT];
   logic [AW-1:0] mem_prev [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;

   logic [31:0] retention_ff, max_bytes_ff;
   logic [8:0]  max_packets_ff;
   rpc_pkg::state_type state_ff, state_in;
   logic [AW-1:0] oldest_ff, oldest_in, newest_ff, newest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [39:0]   bytes_ff, bytes_in;
   logic [63:0]   cnt_ff [7];
   logic [63:0]   cnt_inc;
   logic [2:0]    cnt_sel;
   logic          cnt_en;

   // latched request
   rpc_pkg::action_type act_ff;
   logic [15:0] seq_ff, len_ff;
   logic [31:0] hdl_ff;
   logic [47:0] now_ff;

   logic [AW-1:0] ptr_ff, ptr_in;     // scan index / drop target
   logic [CW-1:0] scan_ff, scan_in;   // scan counter
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_slot_ff, hit_slot_in;
   logic [AW-1:0] new_slot_ff, new_slot_in;
   rpc_pkg::state_type ret_ff, ret_in; // where a drop returns
   logic [3:0]    cidx_ff, cidx_in;

   // registered memory reads
   logic [15:0] rd_seq_ff, rd_len_ff;
   logic [47:0] rd_time_ff;
   logic [31:0] rd_hdl_ff;
   logic [AW-1:0] rd_next_ff, rd_prev_ff;
   logic [AW-1:0] rd_addr;

   // output register
   logic          ov_ff, ov_in;
   logic [119:0]  od_ff, od_in;
   logic [2:0]    ok_ff, ok_in;
   logic          ol_ff, ol_in;

   // write controls
   logic          wr_entry, wr_next, wr_prev;
   logic [AW-1:0] wn_addr, wp_addr, wn_data, wp_data;

   logic [CW-1:0] lim;
   logic [48:0]   age;
   logic          expired;
   logic          over;

   assign lim = (32'(max_packets_ff) > 32'(SLOT_COUNT)) ? CW'(SLOT_COUNT)
                                                       : CW'(max_packets_ff);
   // compare unit: age against retention
   assign age = {1'b0, now_ff} - {1'b0, rd_time_ff};
   assign expired = !age[48] && (age[47:0] >= {16'd0, retention_ff});
   assign over = (count_ff > lim) || (bytes_ff > {8'd0, max_bytes_ff});

   always_ff @(posedge clock) begin
      rd_seq_ff  <= mem_seq[rd_addr];
      rd_len_ff  <= mem_len[rd_addr];
      rd_time_ff <= mem_time[rd_addr];
      rd_hdl_ff  <= mem_hdl[rd_addr];
      rd_next_ff <= mem_next[rd_addr];
      rd_prev_ff <= mem_prev[rd_addr];
      if (wr_entry) begin
         mem_seq[new_slot_ff]  <= seq_ff;
         mem_len[new_slot_ff]  <= len_ff;
         mem_time[new_slot_ff] <= now_ff;
         mem_hdl[new_slot_ff]  <= hdl_ff;
      end
      if (wr_next) mem_next[wn_addr] <= wn_data;
      if (wr_prev) mem_prev[wp_addr] <= wp_data;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (rpc_pkg::action_type'(req_tdata[1:0]) == rpc_pkg::ACT_CLEAR) begin
                  state_in = rpc_pkg::ST_OUT;
               end else begin
                  state_in = rpc_pkg::ST_PRUNE_RD;
               end
            end
         end
         rpc_pkg::ST_PRUNE_RD:  state_in = rpc_pkg::ST_PRUNE_CHK;
         rpc_pkg::ST_PRUNE_CHK: begin
            if (count_ff != '0 && expired) begin
               state_in = rpc_pkg::ST_DROP_WR;
            end else if (act_ff == rpc_pkg::ACT_STATS) begin
               state_in = rpc_pkg::ST_STATS;
            end else begin
               state_in = rpc_pkg::ST_SCAN;
            end
         end
         rpc_pkg::ST_DROP_RD: state_in = rpc_pkg::ST_DROP_WR;
         rpc_pkg::ST_DROP_WR: state_in = ret_ff;
         rpc_pkg::ST_SCAN: begin
            if (scan_ff == CW'(SLOT_COUNT) || hit_ff) begin
               state_in = (act_ff == rpc_pkg::ACT_FIND) ? rpc_pkg::ST_FIND_RD
                                                         : rpc_pkg::ST_STORE_CHK;
            end else begin
               state_in = rpc_pkg::ST_SCAN_CHK;
            end
         end
         rpc_pkg::ST_SCAN_CHK: state_in = rpc_pkg::ST_SCAN;
         rpc_pkg::ST_FIND_RD:  state_in = rpc_pkg::ST_FIND_OUT;
         rpc_pkg::ST_FIND_OUT: state_in = rpc_pkg::ST_OUT;
         rpc_pkg::ST_STORE_CHK: begin
            if (hit_ff) begin
               state_in = rpc_pkg::ST_DROP_RD;
            end else if (len_ff == '0 || {16'd0, len_ff} > max_bytes_ff) begin
               state_in = rpc_pkg::ST_OUT;
            end else if (count_ff >= CW'(SLOT_COUNT)) begin
               state_in = rpc_pkg::ST_DROP_RD;
            end else begin
               state_in = rpc_pkg::ST_FREE;
            end
         end
         rpc_pkg::ST_FREE:     state_in = rpc_pkg::ST_FREE_CHK;
         rpc_pkg::ST_FREE_CHK: state_in = in_use_ff[ptr_ff] ? rpc_pkg::ST_FREE_CHK
                                                            : rpc_pkg::ST_APPEND;
         rpc_pkg::ST_APPEND:   state_in = rpc_pkg::ST_LIMIT;
         rpc_pkg::ST_LIMIT:    state_in = (count_ff != '0 && over) ? rpc_pkg::ST_DROP_RD
                                                                  : rpc_pkg::ST_OUT;
         rpc_pkg::ST_STATS: begin
            if (!ov_ff || rsp_tready) begin
               if (cidx_ff == rpc_pkg::CNT_BYTES) state_in = rpc_pkg::ST_IDLE;
            end
         end
         rpc_pkg::ST_OUT: begin
            if (!ov_ff || rsp_tready) state_in = rpc_pkg::ST_IDLE;
         end
         default: state_in = rpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == rpc_pkg::ST_IDLE);
      in_use_in = in_use_ff;
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      ptr_in = ptr_ff;
      scan_in = scan_ff;
      hit_in = hit_ff;
      hit_slot_in = hit_slot_ff;
      new_slot_in = new_slot_ff;
      ret_in = ret_ff;
      cidx_in = cidx_ff;
      cnt_en = 1'b0;
      cnt_sel = '0;
      rd_addr = ptr_ff;
      wr_entry = 1'b0;
      wr_next = 1'b0;
      wr_prev = 1'b0;
      wn_addr = rd_prev_ff;
      wp_addr = rd_next_ff;
      wn_data = rd_next_ff;
      wp_data = rd_prev_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;
      ok_in = ok_ff;
      ol_in = ol_ff;
      unique case (state_ff)
         rpc_pkg::ST_IDLE: begin
            rd_addr = oldest_ff;
            scan_in = '0;
            hit_in = 1'b0;
            cidx_in = '0;
            if (req_tvalid && rpc_pkg::action_type'(req_tdata[1:0]) == rpc_pkg::ACT_CLEAR) begin
               in_use_in = '0;
               oldest_in = '0;
               newest_in = '0;
               count_in = '0;
               bytes_in = '0;
            end
         end
         rpc_pkg::ST_PRUNE_RD: rd_addr = oldest_ff;
         rpc_pkg::ST_PRUNE_CHK: begin
            rd_addr = oldest_ff;
            ptr_in = oldest_ff;
            ret_in = rpc_pkg::ST_PRUNE_RD;
            if (count_ff != '0 && expired) begin
               cnt_en = 1'b1;
               cnt_sel = 3'(rpc_pkg::CNT_EXPIRED);
            end
         end
         rpc_pkg::ST_DROP_RD: rd_addr = ptr_ff;
         rpc_pkg::ST_DROP_WR: begin
            // unlink ptr_ff; rd_* holds its entry
            if (ptr_ff == oldest_ff) oldest_in = rd_next_ff;
            else wr_next = 1'b1;
            if (ptr_ff == newest_ff) newest_in = rd_prev_ff;
            else wr_prev = 1'b1;
            in_use_in[ptr_ff] = 1'b0;
            bytes_in = bytes_ff - {24'd0, rd_len_ff};
            count_in = count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               oldest_in = '0;
               newest_in = '0;
            end
         end
         rpc_pkg::ST_SCAN: begin
            ptr_in = scan_ff[AW-1:0];
            rd_addr = scan_ff[AW-1:0];
         end
         rpc_pkg::ST_SCAN_CHK: begin
            if (in_use_ff[ptr_ff] && rd_seq_ff == seq_ff) begin
               hit_in = 1'b1;
               hit_slot_in = ptr_ff;
            end
            scan_in = scan_ff + 1'b1;
         end
         rpc_pkg::ST_FIND_RD: begin
            rd_addr = hit_slot_ff;
            // keep the hit entry on the read port until the result goes out
            if (hit_ff) ptr_in = hit_slot_ff;
            cnt_en = 1'b1;
            cnt_sel = 3'(rpc_pkg::CNT_LOOKUPS);
         end
         rpc_pkg::ST_FIND_OUT: begin
            cnt_en = 1'b1;
            cnt_sel = hit_ff ? 3'(rpc_pkg::CNT_HITS) : 3'(rpc_pkg::CNT_MISSES);
         end
         rpc_pkg::ST_STORE_CHK: begin
            ret_in = rpc_pkg::ST_STORE_CHK;
            if (hit_ff) begin
               ptr_in = hit_slot_ff;
               hit_in = 1'b0;
               cnt_en = 1'b1;
               cnt_sel = 3'(rpc_pkg::CNT_REPLACED);
            end else if (len_ff == '0 || {16'd0, len_ff} > max_bytes_ff) begin
               ptr_in = ptr_ff;
            end else if (count_ff >= CW'(SLOT_COUNT)) begin
               ptr_in = oldest_ff;
               cnt_en = 1'b1;
               cnt_sel = 3'(rpc_pkg::CNT_CAPACITY);
            end
         end
         rpc_pkg::ST_FREE: ptr_in = '0;
         rpc_pkg::ST_FREE_CHK: begin
            if (in_use_ff[ptr_ff]) ptr_in = ptr_ff + 1'b1;
            else new_slot_in = ptr_ff;
         end
         rpc_pkg::ST_APPEND: begin
            wr_entry = 1'b1;
            in_use_in[new_slot_ff] = 1'b1;
            if (count_ff == '0) begin
               oldest_in = new_slot_ff;
            end else begin
               wr_next = 1'b1;
               wn_addr = newest_ff;
               wn_data = new_slot_ff;
               wr_prev = 1'b1;
               wp_addr = new_slot_ff;
               wp_data = newest_ff;
            end
            newest_in = new_slot_ff;
            count_in = count_ff + 1'b1;
            bytes_in = bytes_ff + {24'd0, len_ff};
            cnt_en = 1'b1;
            cnt_sel = 3'(rpc_pkg::CNT_STORED);
         end
         rpc_pkg::ST_LIMIT: begin
            ptr_in = oldest_ff;
            ret_in = rpc_pkg::ST_LIMIT;
            if (count_ff != '0 && over) begin
               cnt_en = 1'b1;
               cnt_sel = 3'(rpc_pkg::CNT_CAPACITY);
            end
         end
         rpc_pkg::ST_STATS: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               ok_in = rpc_pkg::KIND_COUNTER;
               ol_in = (cidx_ff == rpc_pkg::CNT_BYTES);
               od_in = '0;
               od_in[52:49] = cidx_ff;
               if (cidx_ff == rpc_pkg::CNT_PACKETS) od_in[116:53] = 64'(count_ff);
               else if (cidx_ff == rpc_pkg::CNT_BYTES) od_in[116:53] = {24'd0, bytes_ff};
               else od_in[116:53] = cnt_ff[cidx_ff[2:0]];
               cidx_in = cidx_ff + 1'b1;
            end
         end
         rpc_pkg::ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               ol_in = 1'b1;
               od_in = '0;
               if (act_ff == rpc_pkg::ACT_CLEAR) begin
                  ok_in = rpc_pkg::KIND_CLEARED;
               end else if (act_ff == rpc_pkg::ACT_FIND) begin
                  ok_in = hit_ff ? rpc_pkg::KIND_HIT : rpc_pkg::KIND_MISS;
                  if (hit_ff) begin
                     od_in[32:1] = rd_hdl_ff;
                     od_in[48:33] = rd_len_ff;
                  end
               end else begin
                  ok_in = rpc_pkg::KIND_STORE;
                  // stored only if the append went in and survived the limits
                  od_in[0] = (len_ff != '0 && {16'd0, len_ff} <= max_bytes_ff)
                             && in_use_ff[new_slot_ff];
               end
            end
         end
         default: ;
      endcase
   end

   assign cnt_inc = cnt_ff[cnt_sel] + 64'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpc_pkg::ST_IDLE;
         in_use_ff <= '0;
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff <= '0;
         bytes_ff <= '0;
         for (int i = 0; i < 7; i++) cnt_ff[i] <= '0;
         retention_ff <= rpc_pkg::RetentionReset;
         max_packets_ff <= rpc_pkg::MaxPacketsReset;
         max_bytes_ff <= rpc_pkg::MaxBytesReset;
         ov_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         in_use_ff <= in_use_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         ov_ff <= ov_in;
         hit_ff <= hit_in;
         if (state_ff == rpc_pkg::ST_IDLE && req_tvalid &&
             rpc_pkg::action_type'(req_tdata[1:0]) == rpc_pkg::ACT_CLEAR) begin
            for (int i = 0; i < 7; i++) cnt_ff[i] <= '0;
         end else if (cnt_en) begin
            cnt_ff[cnt_sel] <= cnt_inc;
         end
         if (csr_wen) begin
            unique case (rpc_pkg::csr_index_type'(csr_index))
               rpc_pkg::CSR_RETENTION:   retention_ff <= csr_wdata;
               rpc_pkg::CSR_MAX_PACKETS: max_packets_ff <= csr_wdata[8:0];
               rpc_pkg::CSR_MAX_BYTES:   max_bytes_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      scan_ff <= scan_in;
      hit_slot_ff <= hit_slot_in;
      new_slot_ff <= new_slot_in;
      ret_ff <= ret_in;
      cidx_ff <= cidx_in;
      od_ff <= od_in;
      ok_ff <= ok_in;
      ol_ff <= ol_in;
      if (state_ff == rpc_pkg::ST_IDLE && req_tvalid) begin
         act_ff <= rpc_pkg::action_type'(req_tdata[1:0]);
         seq_ff <= req_tdata[17:2];
         len_ff <= req_tdata[33:18];
         hdl_ff <= req_tdata[65:34];
         now_ff <= req_tdata[113:66];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ok_ff;
   assign rsp_tlast = ol_ff;
endmodule
`default_nettype wire
